[sv/led_scene_preemption_arbiter_assert.svh]
// ============================================================================
// LED scene preemption arbiter - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef LED_SCENE_PREEMPTION_ARBITER_ASSERT_SVH
`define LED_SCENE_PREEMPTION_ARBITER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define LSPA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define LSPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/lspa_pkg.sv]
// ============================================================================
// LED scene preemption arbiter - package
// Constants, scene definition layout and shared types.
// ============================================================================
`timescale 1ns / 1ps

package lspa_pkg;

    localparam int NUM_SCENES     = 4;
    localparam int NUM_LEDS       = 16;
    localparam int PRIO_BITS      = 8;
    localparam int TIMEOUT_BITS   = 24;
    localparam int SCENE_IDX_BITS = 2;
    localparam int PAUSER_BITS    = 3;
    localparam int OP_BITS        = 2;

    // Definition register layout: defined flag, LED mask, priority, timeout.
    localparam int MASK_SHIFT = 1;
    localparam int PRIO_SHIFT = MASK_SHIFT + NUM_LEDS;
    localparam int TMO_SHIFT  = PRIO_SHIFT + PRIO_BITS;
    localparam int DEF_BITS   = TMO_SHIFT + TIMEOUT_BITS;

    localparam logic [PAUSER_BITS-1:0] NO_PAUSER = PAUSER_BITS'(NUM_SCENES);

    // Request codes carried by an item.
    typedef enum logic [OP_BITS-1:0] {
        OP_RUN  = 2'd0,
        OP_STOP = 2'd1,
        OP_TICK = 2'd2
    } op_t;

    // Per-scene status codes.
    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_PAUSED  = 2'd1,
        ST_RUNNING = 2'd2
    } scene_st_t;

    // Controller states, one-hot.
    typedef enum logic [1:0] {
        CS_IDLE = 2'b01,
        CS_EXEC = 2'b10
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } lspa_cmd_t;

endpackage

[sv/lspa_ctrl.sv]
// ============================================================================
// LED scene preemption arbiter - controller
// Accepts an item, then holds the evaluate state while the datapath evaluates it.
// ============================================================================
`timescale 1ns / 1ps

module lspa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output lspa_pkg::lspa_cmd_t cmd
);

    lspa_pkg::ctrl_state_t state_reg;
    lspa_pkg::ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lspa_pkg::CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            lspa_pkg::CS_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = lspa_pkg::CS_EXEC;
                end
            end
            lspa_pkg::CS_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = lspa_pkg::CS_IDLE;
            end
            default:
            begin
                state_next = lspa_pkg::CS_IDLE;
            end
        endcase
    end

    assign busy = (state_reg == lspa_pkg::CS_EXEC);

endmodule

[sv/lspa_datapath.sv]
// ============================================================================
// LED scene preemption arbiter - datapath
// Scene definitions, per-scene status, pauser and countdown, result registers.
// ============================================================================
`timescale 1ns / 1ps

module lspa_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lspa_pkg::lspa_cmd_t                  cmd,
    input  logic [lspa_pkg::OP_BITS-1:0]         op,
    input  logic [lspa_pkg::SCENE_IDX_BITS-1:0]  scene_index,
    input  logic                                 cfg_we,
    input  logic [lspa_pkg::SCENE_IDX_BITS-1:0]  cfg_index,
    input  logic [lspa_pkg::DEF_BITS-1:0]        cfg_wdata,
    output logic                                 done,
    output logic                                 accepted,
    output logic [lspa_pkg::NUM_SCENES-1:0]      running_scenes,
    output logic [lspa_pkg::NUM_SCENES-1:0]      paused_scenes,
    output logic [lspa_pkg::NUM_LEDS-1:0]        active_leds,
    output logic [lspa_pkg::NUM_SCENES-1:0]      expired_scenes
);

    localparam int NS = lspa_pkg::NUM_SCENES;
    localparam int NL = lspa_pkg::NUM_LEDS;
    localparam int PB = lspa_pkg::PRIO_BITS;
    localparam int TB = lspa_pkg::TIMEOUT_BITS;
    localparam int XB = lspa_pkg::PAUSER_BITS;
    localparam int IB = lspa_pkg::SCENE_IDX_BITS;

    // Scene state and definitions.
    logic [lspa_pkg::DEF_BITS-1:0] def_reg    [NS];
    lspa_pkg::scene_st_t           status_reg [NS];
    lspa_pkg::scene_st_t           status_next[NS];
    logic [XB-1:0]                 pauser_reg [NS];
    logic [XB-1:0]                 pauser_next[NS];
    logic [TB-1:0]                 remain_reg [NS];
    logic [TB-1:0]                 remain_next[NS];

    // Latched item.
    logic [lspa_pkg::OP_BITS-1:0]  op_reg;
    logic [IB-1:0]                 idx_reg;

    // Result registers.
    logic                          done_reg;
    logic                          accepted_reg;
    logic                          accepted_next;
    logic [NS-1:0]                 running_reg;
    logic [NS-1:0]                 running_next;
    logic [NS-1:0]                 paused_reg;
    logic [NS-1:0]                 paused_next;
    logic [NL-1:0]                 leds_reg;
    logic [NL-1:0]                 leds_next;
    logic [NS-1:0]                 expired_reg;
    logic [NS-1:0]                 expired_next;

    // Decoded per-scene terms.
    logic [NL-1:0]                 mask  [NS];
    logic [PB-1:0]                 prio  [NS];
    logic [TB-1:0]                 tmo   [NS];
    logic [NS-1:0]                 sel;
    logic [NS-1:0]                 share;
    logic [NS-1:0]                 pauser_hit;
    logic [NS-1:0]                 dec_live;
    logic [NS-1:0]                 exp_hit;
    logic [NS-1:0]                 resume_tick;
    logic                          req_def;
    logic [NL-1:0]                 req_mask;
    logic [PB-1:0]                 req_prio;
    logic                          refuse;

    // Configuration writes; indexes past the scene count are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                def_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (cfg_we && (cfg_index == IB'(i)))
                begin
                    def_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    // Field decode and requester selection.
    always_comb
    begin
        req_def  = 1'b0;
        req_mask = '0;
        req_prio = '0;
        for (int i = 0; i < NS; i++)
        begin
            mask[i] = def_reg[i][lspa_pkg::MASK_SHIFT +: NL];
            prio[i] = def_reg[i][lspa_pkg::PRIO_SHIFT +: PB];
            tmo[i]  = def_reg[i][lspa_pkg::TMO_SHIFT +: TB];
            sel[i]  = (idx_reg == IB'(i));
            req_def  = req_def | (sel[i] & def_reg[i][0]);
            req_mask = req_mask | (sel[i] ? mask[i] : '0);
            req_prio = req_prio | (sel[i] ? prio[i] : '0);
        end
    end

    // Conflict, resume and countdown terms, one per scene.
    always_comb
    begin
        refuse = 1'b0;
        for (int i = 0; i < NS; i++)
        begin
            share[i] = !sel[i] && (status_reg[i] == lspa_pkg::ST_RUNNING) &&
                       ((mask[i] & req_mask) != '0);
            refuse   = refuse | (share[i] && (prio[i] > req_prio));
            pauser_hit[i] = (status_reg[i] == lspa_pkg::ST_PAUSED) &&
                            (pauser_reg[i] == XB'(idx_reg));
            dec_live[i] = (status_reg[i] == lspa_pkg::ST_RUNNING) &&
                          (remain_reg[i] != '0);
            exp_hit[i]  = dec_live[i] && (remain_reg[i] == TB'(1));
        end
        // A paused scene resumes when its pauser expires on this tick.
        for (int i = 0; i < NS; i++)
        begin
            resume_tick[i] = 1'b0;
            for (int k = 0; k < NS; k++)
            begin
                resume_tick[i] = resume_tick[i] |
                    ((status_reg[i] == lspa_pkg::ST_PAUSED) && exp_hit[k] &&
                     (pauser_reg[i] == XB'(k)));
            end
        end
    end

    // Next scene state for the latched request.
    always_comb
    begin
        accepted_next = 1'b0;
        expired_next  = '0;
        for (int i = 0; i < NS; i++)
        begin
            status_next[i] = status_reg[i];
            pauser_next[i] = pauser_reg[i];
            remain_next[i] = remain_reg[i];
        end
        unique case (op_reg)
            lspa_pkg::OP_RUN:
            begin
                if (req_def && !refuse)
                begin
                    accepted_next = 1'b1;
                    for (int i = 0; i < NS; i++)
                    begin
                        if (sel[i])
                        begin
                            status_next[i] = lspa_pkg::ST_RUNNING;
                            pauser_next[i] = lspa_pkg::NO_PAUSER;
                            remain_next[i] = tmo[i];
                        end
                        else if (share[i])
                        begin
                            status_next[i] = lspa_pkg::ST_PAUSED;
                            pauser_next[i] = XB'(idx_reg);
                            remain_next[i] = '0;
                        end
                    end
                end
            end
            lspa_pkg::OP_STOP:
            begin
                if (req_def)
                begin
                    accepted_next = 1'b1;
                    for (int i = 0; i < NS; i++)
                    begin
                        if (sel[i])
                        begin
                            status_next[i] = lspa_pkg::ST_IDLE;
                            pauser_next[i] = lspa_pkg::NO_PAUSER;
                            remain_next[i] = '0;
                        end
                        else if (pauser_hit[i])
                        begin
                            status_next[i] = lspa_pkg::ST_RUNNING;
                            pauser_next[i] = lspa_pkg::NO_PAUSER;
                            remain_next[i] = tmo[i];
                        end
                    end
                end
            end
            lspa_pkg::OP_TICK:
            begin
                accepted_next = 1'b1;
                expired_next  = exp_hit;
                for (int i = 0; i < NS; i++)
                begin
                    if (exp_hit[i])
                    begin
                        status_next[i] = lspa_pkg::ST_IDLE;
                        pauser_next[i] = lspa_pkg::NO_PAUSER;
                        remain_next[i] = '0;
                    end
                    else if (dec_live[i])
                    begin
                        remain_next[i] = remain_reg[i] - TB'(1);
                    end
                    else if (resume_tick[i])
                    begin
                        status_next[i] = lspa_pkg::ST_RUNNING;
                        pauser_next[i] = lspa_pkg::NO_PAUSER;
                        remain_next[i] = tmo[i];
                    end
                end
            end
            default:
            begin
                accepted_next = 1'b0;
            end
        endcase
    end

    // Summary of the state after the step.
    always_comb
    begin
        leds_next = '0;
        for (int i = 0; i < NS; i++)
        begin
            running_next[i] = (status_next[i] == lspa_pkg::ST_RUNNING);
            paused_next[i]  = (status_next[i] == lspa_pkg::ST_PAUSED);
            leds_next       = leds_next | (running_next[i] ? mask[i] : '0);
        end
    end

    // Scene state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            for (int i = 0; i < NS; i++)
            begin
                status_reg[i] <= lspa_pkg::ST_IDLE;
                pauser_reg[i] <= lspa_pkg::NO_PAUSER;
                remain_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= cmd.exec;
            if (cmd.exec)
            begin
                for (int i = 0; i < NS; i++)
                begin
                    status_reg[i] <= status_next[i];
                    pauser_reg[i] <= pauser_next[i];
                    remain_reg[i] <= remain_next[i];
                end
            end
        end
    end

    // Item capture and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op;
            idx_reg <= scene_index;
        end
        if (cmd.exec)
        begin
            accepted_reg <= accepted_next;
            running_reg  <= running_next;
            paused_reg   <= paused_next;
            leds_reg     <= leds_next;
            expired_reg  <= expired_next;
        end
    end

    assign done           = done_reg;
    assign accepted       = accepted_reg;
    assign running_scenes = running_reg;
    assign paused_scenes  = paused_reg;
    assign active_leds    = leds_reg;
    assign expired_scenes = expired_reg;

endmodule

[sv/led_scene_preemption_arbiter.sv]
// ============================================================================
// LED scene preemption arbiter - top level
// Arbitrates four LED scenes over sixteen shared LEDs by priority and timeout.
// ============================================================================
//
//  Channel   Handshake            Payload
//  -------   ------------------   ---------------------------------------------
//  request   start, busy          op, scene_index
//  result    done (strobe)        accepted, running_scenes, paused_scenes,
//                                 active_leds, expired_scenes
//  config    cfg_we               cfg_index, cfg_wdata
//
//  An item is taken when start is high and busy is low. The controller then
//  holds its evaluate state with busy high, done is high in the cycle after
//  that, and the result is taken at the edge that ends the done cycle. No
//  new item is taken while the previous one is being evaluated.
//  Reset is asynchronous and clears all scenes to idle with no pauser.
//  Results are flagged by done for exactly one cycle; the receiver cannot stall them.
//
`timescale 1ns / 1ps

module led_scene_preemption_arbiter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [lspa_pkg::OP_BITS-1:0]         op,
    input  logic [lspa_pkg::SCENE_IDX_BITS-1:0]  scene_index,
    output logic                                 done,
    output logic                                 accepted,
    output logic [lspa_pkg::NUM_SCENES-1:0]      running_scenes,
    output logic [lspa_pkg::NUM_SCENES-1:0]      paused_scenes,
    output logic [lspa_pkg::NUM_LEDS-1:0]        active_leds,
    output logic [lspa_pkg::NUM_SCENES-1:0]      expired_scenes,
    input  logic                                 cfg_we,
    input  logic [lspa_pkg::SCENE_IDX_BITS-1:0]  cfg_index,
    input  logic [lspa_pkg::DEF_BITS-1:0]        cfg_wdata
);

    lspa_pkg::lspa_cmd_t cmd;

    // Sequencing.
    lspa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    // Scene state and evaluation.
    lspa_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .op             (op),
        .scene_index    (scene_index),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .done           (done),
        .accepted       (accepted),
        .running_scenes (running_scenes),
        .paused_scenes  (paused_scenes),
        .active_leds    (active_leds),
        .expired_scenes (expired_scenes)
    );

    // Checks on sequencing and on the reported scene state.
`include "led_scene_preemption_arbiter_assert.svh"

    `LSPA_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy, "accepted item did not start")
    `LSPA_ASSERT_NEXT(a_busy_gives_result, busy, done, "evaluation gave no result strobe")
    `LSPA_ASSERT_SAME(a_result_when_free, done, !busy, "result strobe while still evaluating")
    `LSPA_ASSERT_SAME(a_disjoint, done, ~|(running_scenes & paused_scenes), "running and paused")
    `LSPA_ASSERT_SAME(a_no_expiry, done && !accepted, ~|expired_scenes, "expiry when refused")

endmodule

[dv/led_scene_preemption_arbiter_test.sv]
// ============================================================================
// LED scene preemption arbiter - self-checking testbench
// Drives run, stop and tick requests through the start/busy handshake and
// checks every status report against an in-bench model of the scene states.
// Scene definitions are rewritten between phases of directed and random items.
// ============================================================================
`timescale 1ns / 1ps

module led_scene_preemption_arbiter_test;

    localparam int NUM_SCENES     = lspa_pkg::NUM_SCENES;
    localparam int NUM_LEDS       = lspa_pkg::NUM_LEDS;
    localparam int PRIO_BITS      = lspa_pkg::PRIO_BITS;
    localparam int TIMEOUT_BITS   = lspa_pkg::TIMEOUT_BITS;
    localparam int SCENE_IDX_BITS = lspa_pkg::SCENE_IDX_BITS;
    localparam int PAUSER_BITS    = lspa_pkg::PAUSER_BITS;
    localparam int OP_BITS        = lspa_pkg::OP_BITS;
    localparam int MASK_SHIFT     = lspa_pkg::MASK_SHIFT;
    localparam int PRIO_SHIFT     = lspa_pkg::PRIO_SHIFT;
    localparam int TMO_SHIFT      = lspa_pkg::TMO_SHIFT;
    localparam int DEF_BITS       = lspa_pkg::DEF_BITS;

    localparam int unsigned CYCLE_LIMIT   = 100_000;
    localparam int          RANDOM_PHASES = 9;
    localparam int          PHASE_ITEMS   = 190;

    // One status report as the block presents it.
    typedef struct packed {
        logic                  accepted;
        logic [NUM_SCENES-1:0] running;
        logic [NUM_SCENES-1:0] paused;
        logic [NUM_LEDS-1:0]   leds;
        logic [NUM_SCENES-1:0] expired;
    } scene_report_t;

    // Kinds of scene definition sets used by the random phases.
    typedef enum int {
        PLAN_MIXED,
        PLAN_ALL_ONES,
        PLAN_ALL_ZERO
    } plan_kind_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks scene states and queues the reports they imply.
    // ------------------------------------------------------------------------
    class scene_arbiter_scoreboard;
        logic [DEF_BITS-1:0]     defs [NUM_SCENES];
        lspa_pkg::scene_st_t     status [NUM_SCENES];
        logic [PAUSER_BITS-1:0]  pauser [NUM_SCENES];
        logic [TIMEOUT_BITS-1:0] remain [NUM_SCENES];
        scene_report_t           due_reports [$];
        int errors;
        int reports_checked;
        int refused_runs;
        int undefined_requests;
        int preemptions;
        int resumes;
        int expiries;

        function new();
            for (int s = 0; s < NUM_SCENES; s++)
            begin
                defs[s]   = '0;
                status[s] = lspa_pkg::ST_IDLE;
                pauser[s] = lspa_pkg::NO_PAUSER;
                remain[s] = '0;
            end
        endfunction

        function void write_def(int s, logic [DEF_BITS-1:0] value);
            defs[s] = value;
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        function logic [NUM_LEDS-1:0] mask_of(int s);
            return defs[s][MASK_SHIFT +: NUM_LEDS];
        endfunction

        function logic [PRIO_BITS-1:0] prio_of(int s);
            return defs[s][PRIO_SHIFT +: PRIO_BITS];
        endfunction

        // A scene (re)starts running with a fresh countdown and no pauser.
        function void launch(int s);
            status[s] = lspa_pkg::ST_RUNNING;
            pauser[s] = lspa_pkg::NO_PAUSER;
            remain[s] = defs[s][TMO_SHIFT +: TIMEOUT_BITS];
        endfunction

        // Stop a scene and bring back every scene that it had paused.
        function void halt(int s);
            status[s] = lspa_pkg::ST_IDLE;
            pauser[s] = lspa_pkg::NO_PAUSER;
            remain[s] = '0;
            for (int j = 0; j < NUM_SCENES; j++)
            begin
                if (status[j] == lspa_pkg::ST_PAUSED && pauser[j] == PAUSER_BITS'(s))
                begin
                    launch(j);
                    resumes++;
                end
            end
        endfunction

        // Refusal is decided before any scene is paused.
        function bit try_run(int s);
            logic [NUM_LEDS-1:0] m;
            m = mask_of(s);
            for (int j = 0; j < NUM_SCENES; j++)
            begin
                if (j != s && status[j] == lspa_pkg::ST_RUNNING &&
                    (mask_of(j) & m) != '0 && prio_of(j) > prio_of(s))
                begin
                    refused_runs++;
                    return 1'b0;
                end
            end
            for (int j = 0; j < NUM_SCENES; j++)
            begin
                if (j != s && status[j] == lspa_pkg::ST_RUNNING && (mask_of(j) & m) != '0)
                begin
                    status[j] = lspa_pkg::ST_PAUSED;
                    pauser[j] = PAUSER_BITS'(s);
                    remain[j] = '0;
                    preemptions++;
                end
            end
            launch(s);
            return 1'b1;
        endfunction

        // Apply one accepted item to the scene states and queue its report.
        function void note_request(lspa_pkg::op_t kind, logic [SCENE_IDX_BITS-1:0] which);
            scene_report_t r;
            int s;
            r = '0;
            s = which;
            unique case (kind)
                lspa_pkg::OP_RUN:
                begin
                    if (defs[s][0]) r.accepted = try_run(s);
                    else undefined_requests++;
                end
                lspa_pkg::OP_STOP:
                begin
                    if (defs[s][0])
                    begin
                        halt(s);
                        r.accepted = 1'b1;
                    end
                    else undefined_requests++;
                end
                lspa_pkg::OP_TICK:
                begin
                    r.accepted = 1'b1;
                    // All countdowns move together; expired scenes stop in index order.
                    for (int i = 0; i < NUM_SCENES; i++)
                    begin
                        if (status[i] == lspa_pkg::ST_RUNNING && remain[i] != '0)
                        begin
                            remain[i] = remain[i] - 1'b1;
                            if (remain[i] == '0) r.expired[i] = 1'b1;
                        end
                    end
                    for (int i = 0; i < NUM_SCENES; i++)
                    begin
                        if (r.expired[i])
                        begin
                            halt(i);
                            expiries++;
                        end
                    end
                end
                default: ;
            endcase
            for (int i = 0; i < NUM_SCENES; i++)
            begin
                if (status[i] == lspa_pkg::ST_RUNNING)
                begin
                    r.running[i] = 1'b1;
                    r.leds = r.leds | mask_of(i);
                end
                else if (status[i] == lspa_pkg::ST_PAUSED)
                begin
                    r.paused[i] = 1'b1;
                end
            end
            due_reports.push_back(r);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("[%0t] mismatch on report %0d: %s got 'h%0h, expected 'h%0h",
                     $time, reports_checked, what, got, want);
            errors++;
        endtask

        task check_report(scene_report_t got);
            scene_report_t want;
            if (due_reports.size() == 0)
            begin
                report_mismatch("unexpected report, whole", got, 0);
                return;
            end
            want = due_reports.pop_front();
            if (got.accepted !== want.accepted)
                report_mismatch("accepted", got.accepted, want.accepted);
            if (got.running !== want.running)
                report_mismatch("running_scenes", got.running, want.running);
            if (got.paused !== want.paused)
                report_mismatch("paused_scenes", got.paused, want.paused);
            if (got.leds !== want.leds)
                report_mismatch("active_leds", got.leds, want.leds);
            if (got.expired !== want.expired)
                report_mismatch("expired_scenes", got.expired, want.expired);
            reports_checked++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block under test.
    // ------------------------------------------------------------------------
    logic                      clk            = 1'b0;
    logic                      rst_n          = 1'b0;
    logic                      start          = 1'b0;
    logic                      busy;
    logic [OP_BITS-1:0]        op             = '0;
    logic [SCENE_IDX_BITS-1:0] scene_index    = '0;
    logic                      done;
    logic                      accepted;
    logic [NUM_SCENES-1:0]     running_scenes;
    logic [NUM_SCENES-1:0]     paused_scenes;
    logic [NUM_LEDS-1:0]       active_leds;
    logic [NUM_SCENES-1:0]     expired_scenes;
    logic                      cfg_we         = 1'b0;
    logic [SCENE_IDX_BITS-1:0] cfg_index      = '0;
    logic [DEF_BITS-1:0]       cfg_wdata      = '0;

    scene_arbiter_scoreboard sb = new();
    logic [DEF_BITS-1:0]     plan [NUM_SCENES];
    plan_kind_t              phase_plan [RANDOM_PHASES] = '{PLAN_MIXED, PLAN_MIXED,
        PLAN_ALL_ONES, PLAN_MIXED, PLAN_MIXED, PLAN_ALL_ZERO, PLAN_MIXED, PLAN_MIXED,
        PLAN_MIXED};
    int unsigned             cycle_count = 0;
    int                      items_sent  = 0;

    led_scene_preemption_arbiter uut (.*);

    // Clock with a 12 ns period.
    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Every strobed report is checked at the edge that ends its cycle.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_report({accepted, running_scenes, paused_scenes, active_leds,
                             expired_scenes});
    end

    // Give up on a hung block.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("led_scene_preemption_arbiter_test: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic logic [DEF_BITS-1:0] make_def(bit defined, logic [NUM_LEDS-1:0] mask,
                                                     logic [PRIO_BITS-1:0] prio,
                                                     logic [TIMEOUT_BITS-1:0] tmo);
        return {tmo, prio, mask, defined};
    endfunction

    // Masks in nibble groups and small priorities make overlaps and ties common.
    function automatic logic [DEF_BITS-1:0] random_def();
        logic [NUM_LEDS-1:0]     mask;
        logic [PRIO_BITS-1:0]    prio;
        logic [TIMEOUT_BITS-1:0] tmo;
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)      mask = NUM_LEDS'($urandom & $urandom);
        else if (pick < 80) mask = NUM_LEDS'(16'h000F) << (4 * $urandom_range(3));
        else if (pick < 92) mask = '1;
        else                mask = '0;
        prio = $urandom_range(1) ? PRIO_BITS'($urandom_range(3)) : PRIO_BITS'($urandom);
        pick = $urandom_range(99);
        if (pick < 65)      tmo = TIMEOUT_BITS'($urandom_range(5, 1));
        else if (pick < 85) tmo = '0;
        else                tmo = TIMEOUT_BITS'($urandom);
        return make_def($urandom_range(99) < 88, mask, prio, tmo);
    endfunction

    function automatic lspa_pkg::op_t pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 45) return lspa_pkg::OP_RUN;
        if (r < 70) return lspa_pkg::OP_STOP;
        return lspa_pkg::OP_TICK;
    endfunction

    // Present one item and hold it until the block takes it.
    task automatic issue(lspa_pkg::op_t kind, logic [SCENE_IDX_BITS-1:0] which);
        start       <= 1'b1;
        op          <= kind;
        scene_index <= which;
        do @(posedge clk); while (busy !== 1'b0);
        sb.note_request(kind, which);
        items_sent++;
    endtask

    // Random gap between items; pct is the idle chance per cycle.
    task automatic pace(int pct);
        if ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < pct);
        end
    endtask

    // Hold off new items until every queued report has come back.
    // With nothing pending the sender is already idle.
    task automatic drain();
        if (sb.pending() != 0)
        begin
            start <= 1'b0;
            while (sb.pending() != 0) @(posedge clk);
        end
    endtask

    // Write the planned definition of every scene, one register per cycle.
    task automatic write_scene_defs();
        for (int s = 0; s < NUM_SCENES; s++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= SCENE_IDX_BITS'(s);
            cfg_wdata <= plan[s];
            @(posedge clk);
            sb.write_def(s, plan[s]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic directed(lspa_pkg::op_t kind, int which);
        issue(kind, SCENE_IDX_BITS'(which));
        pace(22);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int pct;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Scene 0 low priority short timeout, scene 1 higher and shorter,
        // scene 2 every field at its maximum, scene 3 left undefined.
        plan[0] = make_def(1'b1, 16'h000F, 8'd5, 24'd2);
        plan[1] = make_def(1'b1, 16'h0003, 8'd9, 24'd1);
        plan[2] = '1;
        plan[3] = '0;
        write_scene_defs();

        directed(lspa_pkg::OP_TICK, 0);     // tick with nothing running
        directed(lspa_pkg::OP_RUN, 3);      // run of an undefined scene
        directed(lspa_pkg::OP_STOP, 3);     // stop of an undefined scene
        directed(lspa_pkg::OP_RUN, 0);
        directed(lspa_pkg::OP_RUN, 0);      // restart of a running scene
        directed(lspa_pkg::OP_RUN, 1);      // higher priority preempts scene 0
        directed(lspa_pkg::OP_RUN, 0);      // refused while scene 1 holds the LEDs
        directed(lspa_pkg::OP_TICK, 0);     // scene 1 expires, scene 0 resumes
        directed(lspa_pkg::OP_TICK, 0);
        directed(lspa_pkg::OP_TICK, 0);     // resumed scene expires on its reloaded count
        directed(lspa_pkg::OP_RUN, 0);
        directed(lspa_pkg::OP_RUN, 2);      // top priority over all LEDs
        directed(lspa_pkg::OP_RUN, 1);      // refused by scene 2
        directed(lspa_pkg::OP_STOP, 0);     // stop of a paused scene
        directed(lspa_pkg::OP_STOP, 2);     // nothing left to resume
        directed(lspa_pkg::OP_RUN, 1);
        directed(lspa_pkg::OP_RUN, 0);      // refused by scene 1
        directed(lspa_pkg::OP_STOP, 1);
        directed(lspa_pkg::OP_STOP, 1);     // stop of an idle scene
        directed(lspa_pkg::OP_RUN, 2);
        directed(lspa_pkg::OP_RUN, 2);
        directed(lspa_pkg::OP_TICK, 0);     // long countdown does not expire
        directed(lspa_pkg::OP_STOP, 2);

        // Random phases, each with its own scene definitions and idle rate.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain();
            for (int s = 0; s < NUM_SCENES; s++)
            begin
                unique case (phase_plan[ph])
                    PLAN_ALL_ONES: plan[s] = '1;
                    PLAN_ALL_ZERO: plan[s] = '0;
                    default:       plan[s] = random_def();
                endcase
            end
            write_scene_defs();
            pct = (ph < 3) ? 22 : (ph < 6) ? 58 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                issue(pick_op(), SCENE_IDX_BITS'($urandom_range(NUM_SCENES - 1)));
                pace(pct);
                if ($urandom_range(63) == 0) drain();
            end
        end

        drain();
        repeat (4) @(posedge clk);

        $display("Covered %0d items and %0d reports over %0d definition sets.",
                 items_sent, sb.reports_checked, RANDOM_PHASES + 1);
        $display("Saw %0d refused runs, %0d undefined requests, %0d preemptions,",
                 sb.refused_runs, sb.undefined_requests, sb.preemptions);
        $display("%0d resumes and %0d expiries.", sb.resumes, sb.expiries);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("led_scene_preemption_arbiter_test: clean");
        else
            $display("led_scene_preemption_arbiter_test: errors");
        $finish;
    end

endmodule
